// ===== hdl/pwmcap_pkg.sv =====
// Package for the PWM high-time and period capture block.
// Holds the phase, outcome and register index codes and the result record.
// No dependencies.
package pwmcap_pkg;

  // Fixed field widths of the external ports
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PERIOD = 2'd2;

  // Measurement phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_LOW      = 3'd1;
  localparam logic [2:0] PH_RISE     = 3'd2;
  localparam logic [2:0] PH_FALL     = 3'd3;
  localparam logic [2:0] PH_RISE2    = 3'd4;
  localparam logic [2:0] PH_INTERVAL = 3'd5;

  // Outcome codes
  localparam logic [CODE_W-1:0] OUT_FULL        = 3'd0;
  localparam logic [CODE_W-1:0] OUT_NEVER_LOW   = 3'd1;
  localparam logic [CODE_W-1:0] OUT_NEVER_HIGH  = 3'd2;
  localparam logic [CODE_W-1:0] OUT_NO_LOW2     = 3'd3;
  localparam logic [CODE_W-1:0] OUT_NO_HIGH2    = 3'd4;

  // One measurement result
  typedef struct packed {
    logic [DATA_W-1:0] high_time;
    logic [DATA_W-1:0] period_ticks;
    logic [CODE_W-1:0] outcome;
  } result_t;

endpackage

// ===== hdl/pwmcap_sample_if.sv =====
// Valid/ready channel carrying one sampled pin level per request.
// No dependencies.
interface pwmcap_sample_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== hdl/pwmcap_result_if.sv =====
// Valid/ready channel carrying one measurement result per request.
// Depends on pwmcap_pkg for the field widths.
interface pwmcap_result_if;
  import pwmcap_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] high_time;
  logic [DATA_W-1:0] period_ticks;
  logic [CODE_W-1:0] outcome;

  modport source (output valid, output high_time, output period_ticks, output outcome,
                  input ready);
  modport sink   (input valid, input high_time, input period_ticks, input outcome,
                  output ready);
endinterface

// ===== hdl/pwmcap_meas.sv =====
// Measurement state machine: schedule counters, edge tracking, deadline check
// and period estimate. Handles one sample per enabled cycle.
// Depends on pwmcap_pkg.
module pwmcap_meas #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                pin_i,
  input  logic                                cfg_we_i,
  input  logic [pwmcap_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pwmcap_pkg::DATA_W-1:0]       cfg_data_i,
  output logic                                res_valid_o,
  output pwmcap_pkg::result_t                 res_o
);
  import pwmcap_pkg::*;

  localparam int unsigned E10_W = TICK_WIDTH + 4;  // holds 10 * elapsed
  localparam int unsigned L17_W = TICK_WIDTH + 5;  // holds 17 * period
  localparam logic [TICK_WIDTH-1:0] TMAX = '1;
  localparam logic [E10_W-1:0]      TEN  = E10_W'(10);

  logic [2:0]            phase_q, phase_d;
  logic [DATA_W-1:0]     wait_q, wait_d;
  logic [DATA_W-1:0]     delay_q, delay_d;
  logic [DATA_W-1:0]     interval_q, interval_d;
  logic [TICK_WIDTH-1:0] elapsed_q, elapsed_d;
  logic [E10_W-1:0]      e10_q, e10_d;
  logic [L17_W-1:0]      lim17_q, lim17_d;
  logic [TICK_WIDTH-1:0] rise_q, rise_d;
  logic [TICK_WIDTH-1:0] fall_q, fall_d;
  logic [TICK_WIDTH-1:0] period_q, period_d;

  logic                  waiting, starting, timeout;
  logic [DATA_W-1:0]     limit;
  logic [2:0]            cur_phase;
  logic [TICK_WIDTH-1:0] t, rise_c, fall_c, diff, period_step;
  logic [E10_W-1:0]      t10;
  logic [L17_W-1:0]      lim_c;

  // Deadline test: t > floor(17p/10) is the same as 17p < 10t
  always_comb begin
    waiting   = (phase_q == PH_START) || (phase_q == PH_INTERVAL);
    limit     = (phase_q == PH_START) ? delay_q : interval_q;
    starting  = waiting && !(wait_q < limit);
    cur_phase = starting ? PH_LOW : phase_q;
    t         = starting ? '0 : elapsed_q;
    t10       = starting ? '0 : e10_q;
    rise_c    = starting ? '0 : rise_q;
    fall_c    = starting ? '0 : fall_q;
    lim_c     = starting ? (L17_W'({period_q, 4'b0000}) + L17_W'(period_q)) : lim17_q;
    timeout   = (lim_c < {1'b0, t10}) || (t == TMAX);
    diff      = fall_c - rise_c;
  end

  // Per-sample step, then configuration writes
  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    delay_d     = delay_q;
    interval_d  = interval_q;
    elapsed_d   = elapsed_q;
    e10_d       = e10_q;
    lim17_d     = lim17_q;
    rise_d      = rise_q;
    fall_d      = fall_q;
    period_step = period_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (waiting && !starting) begin
        wait_d = wait_q + 1'b1;
      end else begin
        phase_d   = cur_phase;
        elapsed_d = t;
        e10_d     = t10;
        lim17_d   = lim_c;
        rise_d    = rise_c;
        fall_d    = fall_c;
        if (timeout) begin
          res_valid_o = 1'b1;
          phase_d     = PH_INTERVAL;
          wait_d      = '0;
          case (cur_phase)
            PH_LOW: begin
              res_o.high_time = DATA_W'(period_q);
              res_o.outcome   = OUT_NEVER_LOW;
            end
            PH_RISE: begin
              res_o.high_time = '0;
              res_o.outcome   = OUT_NEVER_HIGH;
            end
            PH_FALL: begin
              res_o.high_time = DATA_W'(period_q);
              res_o.outcome   = OUT_NO_LOW2;
            end
            default: begin
              res_o.high_time = DATA_W'(diff);
              res_o.outcome   = OUT_NO_HIGH2;
            end
          endcase
        end else begin
          elapsed_d = t + 1'b1;
          e10_d     = t10 + TEN;
          case (cur_phase)
            PH_LOW: begin
              if (!pin_i) phase_d = PH_RISE;
            end
            PH_RISE: begin
              if (pin_i) begin
                rise_d  = t;
                phase_d = PH_FALL;
              end
            end
            PH_FALL: begin
              if (!pin_i) begin
                fall_d  = t;
                phase_d = PH_RISE2;
              end
            end
            default: begin
              // second rising edge closes a full measurement
              if (pin_i) begin
                period_step     = t - rise_c;
                res_valid_o     = 1'b1;
                res_o.high_time = DATA_W'(diff);
                res_o.outcome   = OUT_FULL;
                phase_d         = PH_INTERVAL;
                wait_d          = '0;
              end
            end
          endcase
        end
      end
    end
    res_o.period_ticks = DATA_W'(period_step);

    period_d = period_step;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_DELAY: begin
          delay_d = cfg_data_i;
          phase_d = PH_START;
          wait_d  = '0;
        end
        CFG_INTERVAL:    interval_d = cfg_data_i;
        CFG_INIT_PERIOD: period_d   = TICK_WIDTH'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      wait_q     <= '0;
      delay_q    <= '0;
      interval_q <= '0;
      elapsed_q  <= '0;
      e10_q      <= '0;
      lim17_q    <= '0;
      rise_q     <= '0;
      fall_q     <= '0;
      period_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      wait_q     <= wait_d;
      delay_q    <= delay_d;
      interval_q <= interval_d;
      elapsed_q  <= elapsed_d;
      e10_q      <= e10_d;
      lim17_q    <= lim17_d;
      rise_q     <= rise_d;
      fall_q     <= fall_d;
      period_q   <= period_d;
    end
  end

`ifndef ASSERT_OFF
  // the scaled tick count tracks the plain one
  a_e10_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e10_q == ((E10_W'(elapsed_q) << 3) + (E10_W'(elapsed_q) << 1)))
    else $error("scaled elapsed count out of step");

  // a recorded rise lies in the past of the running measurement
  a_rise_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FALL || phase_q == PH_RISE2) |-> (rise_q < elapsed_q))
    else $error("rise time not before elapsed count");

  // the fall follows the rise
  a_fall_after_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RISE2) |-> (fall_q > rise_q))
    else $error("fall time not after rise time");

  // every result restarts the interval wait
  a_result_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !cfg_we_i) |=> (phase_q == PH_INTERVAL && wait_q == '0))
    else $error("result did not re-arm the interval wait");
`endif

endmodule

// ===== hdl/pwm_high_time_period_capture_core.sv =====
// Top level of the PWM high-time and period capture block.
// Depends on pwmcap_pkg, pwmcap_sample_if, pwmcap_result_if and pwmcap_meas.
//
// Usage: one pin sample per request arrives on the sample channel, normally
// one per timer tick. After start_delay samples, and again interval_ticks
// samples after each result, a measurement runs: it waits for low, a rising
// edge, a falling edge and the next rising edge within 1.7 times the period
// estimate. Each measurement yields one request on the result channel with
// the high time, the period estimate and an outcome code.
// The closing sample is registered in the input register, then processed into
// the result register, which drives the result channel; a stall on the result
// side can hold the sample in the input register between the two.
// Throughput: one sample per cycle while the result side takes its requests.
// Stall: a result waits in the output register; one more sample may enter the
// input register, after which sample ready drops until the result is taken.
// Reset: asynchronous; valid flags and measurement state clear, period
// estimate zero, schedule in the start wait.
// Configuration writes are taken at any edge with cfg_we_i high; index 0
// restarts the schedule, index 2 loads the period estimate.
module pwm_high_time_period_capture_core #(
  parameter int unsigned TICK_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pwmcap_sample_if.sink                    sample_i,
  pwmcap_result_if.source                  result_o,
  input  logic                             cfg_we_i,
  input  logic [pwmcap_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pwmcap_pkg::DATA_W-1:0]    cfg_data_i
);
  import pwmcap_pkg::*;

  logic    s1_valid_q, s1_pin_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance, step, res_valid;
  result_t res;

  // Output slot free or being emptied this cycle
  assign advance         = !out_valid_q || result_o.ready;
  assign step            = s1_valid_q && advance;
  assign sample_i.ready  = !s1_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.valid && sample_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      s1_pin_q <= sample_i.pin_level;
    end
  end

  pwmcap_meas #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_meas (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pin_i       (s1_pin_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.high_time    = out_q.high_time;
  assign result_o.period_ticks = out_q.period_ticks;
  assign result_o.outcome      = out_q.outcome;

endmodule

// ===== tb/pwmcap_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the PWM capture testbench: a per-sample model of the capture
// schedule and the queue of results it expects from the block.
// Depends on pwmcap_pkg.
package pwmcap_tb_pkg;
  import pwmcap_pkg::*;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]    TICK_MAX   = '1;

  class pwmcap_scoreboard;
    logic [DATA_W-1:0] start_delay;
    logic [DATA_W-1:0] interval_ticks;
    logic [DATA_W-1:0] period_est;
    logic [2:0]        phase;
    logic [DATA_W-1:0] wait_cnt;
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] deadline;
    logic [DATA_W-1:0] rise_t;
    logic [DATA_W-1:0] fall_t;
    result_t           expected_q[$];
    int unsigned       fail_cnt;

    function new();
      start_delay    = '0;
      interval_ticks = '0;
      period_est     = '0;
      phase          = PH_START;
      wait_cnt       = '0;
      elapsed        = '0;
      deadline       = '0;
      rise_t         = '0;
      fall_t         = '0;
      fail_cnt       = 0;
    endfunction

    // floor(p * 1.7), clipped to the tick range
    function logic [DATA_W-1:0] stretch_period(logic [DATA_W-1:0] p);
      longint unsigned q;
      longint unsigned frac;
      q    = p / 10;
      frac = ((p % 10) * 17) / 10;
      if (q > (64'hFFFF_FFFF - frac) / 17) return TICK_MAX;
      return DATA_W'(q * 17 + frac);
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_START_DELAY: begin
          start_delay = value;
          phase       = PH_START;
          wait_cnt    = '0;
        end
        CFG_INTERVAL:    interval_ticks = value;
        CFG_INIT_PERIOD: period_est = value;
        default: ;
      endcase
    endfunction

    function void close_measurement(logic [DATA_W-1:0] high, logic [CODE_W-1:0] code);
      result_t r;
      r.high_time    = high;
      r.period_ticks = period_est;
      r.outcome      = code;
      expected_q.push_back(r);
      phase    = PH_INTERVAL;
      wait_cnt = '0;
    endfunction

    // Advance the capture schedule by one accepted pin sample
    function void note_sample(logic level);
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] limit;
      if (phase == PH_START || phase == PH_INTERVAL) begin
        limit = (phase == PH_START) ? start_delay : interval_ticks;
        if (wait_cnt < limit) begin
          wait_cnt++;
          return;
        end
        // this sample is the first of the new measurement
        phase    = PH_LOW;
        elapsed  = '0;
        deadline = stretch_period(period_est);
        rise_t   = '0;
        fall_t   = '0;
      end
      t = elapsed;
      // timeout wins over whatever the pin shows on this tick
      if (t > deadline || t == TICK_MAX) begin
        case (phase)
          PH_LOW:  close_measurement(period_est, OUT_NEVER_LOW);
          PH_RISE: close_measurement('0, OUT_NEVER_HIGH);
          PH_FALL: close_measurement(period_est, OUT_NO_LOW2);
          default: close_measurement(fall_t - rise_t, OUT_NO_HIGH2);
        endcase
        return;
      end
      elapsed = t + 1;
      case (phase)
        PH_LOW:  if (!level) phase = PH_RISE;
        PH_RISE: if (level) begin
          rise_t = t;
          phase  = PH_FALL;
        end
        PH_FALL: if (!level) begin
          fall_t = t;
          phase  = PH_RISE2;
        end
        default: if (level) begin
          period_est = t - rise_t;
          close_measurement(fall_t - rise_t, OUT_FULL);
        end
      endcase
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      fail_cnt++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result request with none expected: high %0d period %0d outcome %0d",
                         got.high_time, got.period_ticks, got.outcome));
        return;
      end
      want = expected_q.pop_front();
      if (got.high_time !== want.high_time)
        report($sformatf("high_time %0d, expected %0d", got.high_time, want.high_time));
      if (got.period_ticks !== want.period_ticks)
        report($sformatf("period_ticks %0d, expected %0d", got.period_ticks,
                         want.period_ticks));
      if (got.outcome !== want.outcome)
        report($sformatf("outcome %0d, expected %0d", got.outcome, want.outcome));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== tb/pwm_high_time_period_capture_core_test.sv =====
`timescale 1ns / 1ps
// Top of the PWM capture testbench: clock, reset, sample and result drivers,
// directed measurements per outcome and randomised pulse trains.
// Depends on pwmcap_pkg, both channel interfaces, pwmcap_tb_pkg and the core.
module pwm_high_time_period_capture_core_test;
  import pwmcap_pkg::*;
  import pwmcap_tb_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 950;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  pwmcap_sample_if smp ();
  pwmcap_result_if res ();

  pwmcap_scoreboard sb;
  bit               calm      = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      sent_cnt  = 0;

  pwm_high_time_period_capture_core i_dut (
    .clk_i,
    .rst_ni,
    .sample_i  (smp),
    .result_o  (res),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each accepted request, then pick the next ready
  initial begin
    result_t got;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        got.high_time    = res.high_time;
        got.period_ticks = res.period_ticks;
        got.outcome      = res.outcome;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < 25) begin
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Offer one pin sample, with an occasional gap first
  task automatic offer_sample(input logic level);
    if (!calm && $urandom_range(99) < 25) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    smp.valid     <= 1'b1;
    smp.pin_level <= level;
    do @(posedge clk_i); while (!smp.ready);
    sb.note_sample(level);
    sent_cnt++;
  endtask

  task automatic send_pattern(input string bits);
    for (int i = 0; i < bits.len(); i++) offer_sample(bits[i] == "1");
  endtask

  // Pulse train with random phase, a little noise and occasional retiming
  task automatic drive_pwm(input int unsigned n, input int unsigned hi_len,
                           input int unsigned lo_len);
    int unsigned pos;
    logic        level;
    pos = $urandom_range(0, hi_len + lo_len - 1);
    repeat (n) begin
      level = (pos < hi_len);
      if ($urandom_range(99) < 4) level = ~level;
      offer_sample(level);
      pos = (pos + 1) % (hi_len + lo_len);
      if (pos == 0 && $urandom_range(99) < 10) begin
        hi_len = $urandom_range(1, 8);
        lo_len = $urandom_range(1, 8);
      end
    end
  endtask

  // Stop sending and let every expected result and in-flight sample clear
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the selected registers in index order; bit 3 hits the unused index
  task automatic write_settings(input bit [3:0] sel, input logic [DATA_W-1:0] sd,
                                input logic [DATA_W-1:0] iv, input logic [DATA_W-1:0] ip);
    logic [DATA_W-1:0]    vals [4];
    logic [CFG_IDX_W-1:0] idx_tab [4] = '{CFG_START_DELAY, CFG_INTERVAL, CFG_INIT_PERIOD,
                                          CFG_UNUSED};
    vals[0] = sd;
    vals[1] = iv;
    vals[2] = ip;
    vals[3] = $urandom();
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= idx_tab[i];
        cfg_data_i <= vals[i];
        @(posedge clk_i);
        sb.load_register(idx_tab[i], vals[i]);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // period 2 gives a deadline of 3: ticks 0..3 measure, tick 4 times out
    write_settings(4'b1111, '0, '0, 32'd2);
    send_pattern("11111");  // never low
    send_pattern("00000");  // never high
    send_pattern("01111");  // no second low
    send_pattern("01000");  // no second high
    send_pattern("0101");   // full, period stays 2
    drain();
    // zero period: the second tick of each measurement is already late
    write_settings(4'b0100, '0, '0, '0);
    send_pattern("1000");
    drain();
  endtask

  task automatic run_random();
    int unsigned       round_no;
    int unsigned       kind;
    int unsigned       n;
    logic [DATA_W-1:0] sd;
    logic [DATA_W-1:0] iv;
    logic [DATA_W-1:0] ip;
    bit [3:0]          sel;
    round_no = 0;
    sent_cnt = 0;
    while (sent_cnt < RANDOM_ITEMS) begin
      sd   = $urandom_range(0, 30);
      iv   = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      ip   = $urandom_range(0, 60);
      sel  = 4'($urandom_range(1, 15));
      kind = $urandom_range(0, 9);
      case (round_no)
        0: begin  // deadline saturates, only a full train can end it
          sd   = '0;
          ip   = TICK_MAX;
          sel  = 4'b0101;
          kind = 0;
        end
        1: begin  // schedule never leaves the start wait
          sd  = TICK_MAX;
          sel = 4'b0001;
        end
        2: begin  // one measurement, then an endless interval
          sd   = '0;
          iv   = TICK_MAX;
          sel  = 4'b0011;
          kind = 0;
        end
        3: begin  // shortened interval takes over at once, zero deadline
          iv  = '0;
          ip  = '0;
          sel = 4'b0110;
        end
        5: begin  // result side held off while samples keep coming
          sd   = '0;
          iv   = '0;
          ip   = 32'd8;
          sel  = 4'b0111;
          kind = 0;
        end
        default: ;
      endcase
      write_settings(sel, sd, iv, ip);
      if (round_no == 5) hold_left = HOLD_CYCLES;
      calm = (round_no == 6);
      n    = $urandom_range(40, 120);
      if (kind < 7) begin
        drive_pwm(n, $urandom_range(1, 8), $urandom_range(1, 8));
      end else if (kind == 7) begin
        sd[0] = $urandom_range(1);
        repeat (n) offer_sample(sd[0]);
      end else begin
        repeat (n) offer_sample($urandom_range(1));
      end
      drain();
      calm = 1'b0;
      round_no++;
    end
  endtask

  // Stimulus
  initial begin
    sb            = new();
    smp.valid     = 1'b0;
    smp.pin_level = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_START_DELAY;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    smp.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
